FILE: src/wsp_pkg.sv
// Shared types and constants for the WAV stream PCM decoder.
// No dependencies; imported by the parser, queue, output stage and top level.
package wsp_pkg;

    // Chunk and magic tags, first byte in the high bits
    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic [31:0] FMT_LEN = 32'd16;
    localparam logic [7:0]  PCM_OFFSET = 8'd128;

    // Result kinds
    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    // Status codes
    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_NOT_RIFF  = 4'd1;
    localparam logic [3:0] ST_NOT_WAVE  = 4'd2;
    localparam logic [3:0] ST_SHORT_FMT = 4'd3;
    localparam logic [3:0] ST_NOT_PCM   = 4'd4;
    localparam logic [3:0] ST_CHANNELS  = 4'd5;
    localparam logic [3:0] ST_RATE      = 4'd6;
    localparam logic [3:0] ST_BITS      = 4'd7;
    localparam logic [3:0] ST_NO_DATA   = 4'd8;
    localparam logic [3:0] ST_TRUNC     = 4'd9;

    // One queued result: word is the raw sample bytes or the frame count
    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  status;
        logic [31:0] word;
        logic [30:0] rate;
        logic [1:0]  channels;
        logic        width_16;
        logic        fin;
    } wsp_rec_t;

endpackage

FILE: src/wsp_parse.sv
// Front end: byte-serial RIFF/WAVE chunk parser that classifies each byte.
// Depends on wsp_pkg; pushes at most one result record per accepted byte.
module wsp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_fire,
    input  logic [7:0]        file_byte,
    input  logic              end_of_file,
    output logic              push,
    output wsp_pkg::wsp_rec_t rec
);
    import wsp_pkg::*;

    typedef enum logic [8:0] {
        PH_RIFF = 9'b000000001,
        PH_SIZE = 9'b000000010,
        PH_WAVE = 9'b000000100,
        PH_HEAD = 9'b000001000,
        PH_FMT  = 9'b000010000,
        PH_SKIP = 9'b000100000,
        PH_DATA = 9'b001000000,
        PH_TAIL = 9'b010000000,
        PH_DEAD = 9'b100000000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  idx_reg, idx_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] left_reg, left_next;
    logic [31:0] buf_reg, buf_next;
    logic [1:0]  ch_reg, ch_next;
    logic [30:0] rate_reg, rate_next;
    logic        w16_reg, w16_next;
    logic        fvalid_reg, fvalid_next;
    logic [31:0] frames_reg, frames_next;
    logic [2:0]  fbytes_reg, fbytes_next;
    logic [1:0]  fbi_reg, fbi_next;
    logic        pad_reg, pad_next;

    logic [3:0]  err;
    logic        fin;
    logic [31:0] byte_w;
    logic [31:0] len;
    logic [1:0]  shamt;

    assign byte_w = {24'd0, file_byte};

    // Parse one byte
    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        tag_next    = tag_reg;
        left_next   = left_reg;
        buf_next    = buf_reg;
        ch_next     = ch_reg;
        rate_next   = rate_reg;
        w16_next    = w16_reg;
        fvalid_next = fvalid_reg;
        frames_next = frames_reg;
        fbytes_next = fbytes_reg;
        fbi_next    = fbi_reg;
        pad_next    = pad_reg;
        err   = ST_OK;
        fin   = 1'b0;
        push  = 1'b0;
        rec   = '0;
        len   = '0;
        shamt = '0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_RIFF, PH_WAVE:
                begin
                    tag_next = {tag_reg[23:0], file_byte};
                    if (idx_reg >= 5'd3)
                    begin
                        idx_next = '0;
                        if (phase_reg == PH_RIFF)
                        begin
                            if (tag_next != TAG_RIFF) err = ST_NOT_RIFF;
                            else phase_next = PH_SIZE;
                        end
                        else
                        begin
                            if (tag_next != TAG_WAVE) err = ST_NOT_WAVE;
                            else phase_next = PH_HEAD;
                        end
                    end
                    else
                        idx_next = idx_reg + 5'd1;
                end
                PH_SIZE:
                begin
                    if (idx_reg >= 5'd3)
                    begin
                        idx_next   = '0;
                        phase_next = PH_WAVE;
                    end
                    else
                        idx_next = idx_reg + 5'd1;
                end
                PH_HEAD:
                begin
                    if (idx_reg < 5'd4)
                    begin
                        tag_next = (idx_reg == 5'd0) ? byte_w : {tag_reg[23:0], file_byte};
                        idx_next = idx_reg + 5'd1;
                    end
                    else
                    begin
                        buf_next = (idx_reg == 5'd4) ? byte_w
                                 : (buf_reg | (byte_w << {idx_reg[1:0], 3'b000}));
                        if (idx_reg < 5'd7)
                            idx_next = idx_reg + 5'd1;
                        else
                        begin
                            len       = buf_next;
                            pad_next  = len[0];
                            left_next = len;
                            idx_next  = '0;
                            if (tag_reg == TAG_FMT)
                            begin
                                fvalid_next = 1'b0;
                                if (len < FMT_LEN)
                                    err = ST_SHORT_FMT;
                                else
                                begin
                                    left_next  = len - FMT_LEN;
                                    phase_next = PH_FMT;
                                end
                            end
                            else if (tag_reg == TAG_DATA && fvalid_reg && len != 32'd0)
                            begin
                                shamt       = {1'b0, ch_reg == 2'd2} + {1'b0, w16_reg};
                                frames_next = len >> shamt;
                                fbytes_next = 3'd1 << shamt;
                                fbi_next    = '0;
                                buf_next    = '0;
                                push         = 1'b1;
                                rec.kind     = KIND_HEADER;
                                rec.word     = frames_next;
                                rec.rate     = rate_reg;
                                rec.channels = ch_reg;
                                rec.width_16 = w16_reg;
                                phase_next = (frames_next == 32'd0) ? PH_TAIL : PH_DATA;
                            end
                            else
                                phase_next = (len != 32'd0) ? PH_SKIP : PH_HEAD;
                        end
                    end
                end
                PH_FMT:
                begin
                    unique case (idx_reg)
                        5'd0, 5'd2, 5'd4, 5'd14: buf_next = byte_w;
                        5'd1, 5'd3, 5'd15:       buf_next = buf_reg | (byte_w << 8);
                        5'd5, 5'd6, 5'd7:
                            buf_next = buf_reg | (byte_w << {idx_reg[1:0], 3'b000});
                        default:                 buf_next = buf_reg;
                    endcase
                    if (idx_reg == 5'd1 && buf_next != 32'd1)
                        err = ST_NOT_PCM;
                    if (idx_reg == 5'd3)
                    begin
                        if (buf_next != 32'd1 && buf_next != 32'd2) err = ST_CHANNELS;
                        else ch_next = buf_next[1:0];
                    end
                    if (idx_reg == 5'd7)
                    begin
                        if (buf_next == 32'd0 || buf_next[31]) err = ST_RATE;
                        else rate_next = buf_next[30:0];
                    end
                    if (idx_reg >= 5'd15)
                    begin
                        if (buf_next != 32'd8 && buf_next != 32'd16)
                            err = ST_BITS;
                        else
                        begin
                            w16_next    = (buf_next == 32'd16);
                            fvalid_next = 1'b1;
                            phase_next  = (left_reg != 32'd0 || pad_reg) ? PH_SKIP : PH_HEAD;
                            idx_next    = '0;
                        end
                    end
                    else
                        idx_next = idx_reg + 5'd1;
                end
                PH_SKIP:
                begin
                    if (left_reg != 32'd0) left_next = left_reg - 32'd1;
                    else pad_next = 1'b0;
                    if (left_next == 32'd0 && !pad_next) phase_next = PH_HEAD;
                    idx_next = '0;
                end
                PH_DATA:
                begin
                    buf_next = (fbi_reg == 2'd0) ? byte_w
                             : (buf_reg | (byte_w << {fbi_reg, 3'b000}));
                    if (({1'b0, fbi_reg} + 3'd1) >= fbytes_reg)
                    begin
                        push         = 1'b1;
                        rec.kind     = KIND_SAMPLE;
                        rec.word     = buf_next;
                        rec.channels = ch_reg;
                        rec.width_16 = w16_reg;
                        fbi_next     = '0;
                        if (frames_reg != 32'd0) frames_next = frames_reg - 32'd1;
                        if (frames_next == 32'd0) phase_next = PH_TAIL;
                    end
                    else
                        fbi_next = fbi_reg + 2'd1;
                end
                PH_TAIL: ;
                PH_DEAD: ;
                default: phase_next = PH_DEAD;
            endcase

            // Report the first failure and stop the file
            if (err != ST_OK)
            begin
                push       = 1'b1;
                rec        = '0;
                rec.kind   = KIND_ERROR;
                rec.status = err;
                rec.fin    = 1'b1;
                fin        = 1'b1;
                phase_next = PH_DEAD;
            end

            // Close the file on its last byte
            if (end_of_file && !fin)
            begin
                priority if (phase_next == PH_RIFF || phase_next == PH_SIZE
                             || phase_next == PH_WAVE)
                begin
                    push = 1'b1; rec = '0;
                    rec.kind = KIND_ERROR; rec.status = ST_TRUNC; rec.fin = 1'b1;
                end
                else if (phase_next == PH_FMT)
                begin
                    push = 1'b1; rec = '0;
                    rec.kind = KIND_ERROR; rec.status = ST_SHORT_FMT; rec.fin = 1'b1;
                end
                else if (phase_next == PH_HEAD || phase_next == PH_SKIP)
                begin
                    push = 1'b1; rec = '0;
                    rec.kind = KIND_ERROR; rec.status = ST_NO_DATA; rec.fin = 1'b1;
                end
                else if (phase_next == PH_DATA)
                begin
                    push = 1'b1; rec = '0;
                    rec.kind = KIND_END; rec.status = ST_TRUNC; rec.fin = 1'b1;
                end
                else if (phase_next == PH_TAIL)
                begin
                    if (push)
                        rec.fin = 1'b1;
                    else
                    begin
                        push = 1'b1; rec = '0;
                        rec.kind = KIND_END; rec.status = ST_OK; rec.fin = 1'b1;
                    end
                end
                else
                begin
                    push = push;
                end
            end

            // Return to the reset state for the next file
            if (end_of_file)
            begin
                phase_next  = PH_RIFF;
                idx_next    = '0;
                tag_next    = '0;
                left_next   = '0;
                buf_next    = '0;
                ch_next     = '0;
                rate_next   = '0;
                w16_next    = 1'b0;
                fvalid_next = 1'b0;
                frames_next = '0;
                fbytes_next = '0;
                fbi_next    = '0;
                pad_next    = 1'b0;
            end
        end
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_RIFF;
            idx_reg    <= '0;
            tag_reg    <= '0;
            left_reg   <= '0;
            buf_reg    <= '0;
            ch_reg     <= '0;
            rate_reg   <= '0;
            w16_reg    <= 1'b0;
            fvalid_reg <= 1'b0;
            frames_reg <= '0;
            fbytes_reg <= '0;
            fbi_reg    <= '0;
            pad_reg    <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            tag_reg    <= tag_next;
            left_reg   <= left_next;
            buf_reg    <= buf_next;
            ch_reg     <= ch_next;
            rate_reg   <= rate_next;
            w16_reg    <= w16_next;
            fvalid_reg <= fvalid_next;
            frames_reg <= frames_next;
            fbytes_reg <= fbytes_next;
            fbi_reg    <= fbi_next;
            pad_reg    <= pad_next;
        end
    end

    // Frames only count down while samples are being produced
    a_data_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> frames_reg != 32'd0)
        else $error("data phase with no frames left");
    a_push_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> in_fire)
        else $error("result without an accepted byte");
    a_eof_resets: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_file |=> phase_reg == PH_RIFF)
        else $error("parser did not restart after end of file");

endmodule

FILE: src/wsp_fifo.sv
// Short result queue between the parser and the output stage.
// Depends on wsp_pkg for the record type.
module wsp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsp_pkg::wsp_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output wsp_pkg::wsp_rec_t head_rec
);
    import wsp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    wsp_rec_t        mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == CW'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_rec   = mem_reg[rd_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
            wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
        if (pop)
            rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);
        if (push && !pop)
            cnt_next = cnt_reg + CW'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_rec;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

FILE: src/wsp_out.sv
// Back end: formats queued records into result beats behind an output register.
// Depends on wsp_pkg; converts 8-bit PCM and duplicates mono.
module wsp_out (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  wsp_pkg::wsp_rec_t head_rec,
    output logic              pop,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [111:0]      m_axis_tdata,
    output logic [1:0]        m_axis_tuser,
    output logic              m_axis_tlast
);
    import wsp_pkg::*;

    logic         valid_reg;
    logic [111:0] data_reg, data_next;
    logic [1:0]   user_reg;
    logic         last_reg;
    logic [15:0]  left_s, right_s;
    logic [30:0]  rate_f;
    logic [1:0]   ch_f;
    logic [4:0]   bits_f;
    logic [31:0]  frames_f;
    logic         stereo;

    assign pop = head_valid && (!valid_reg || m_axis_tready);
    assign stereo = (head_rec.channels == 2'd2);

    // Build sample and header fields
    always_comb
    begin
        left_s   = '0;
        right_s  = '0;
        rate_f   = '0;
        ch_f     = '0;
        bits_f   = '0;
        frames_f = '0;
        if (head_rec.kind == KIND_SAMPLE)
        begin
            if (head_rec.width_16)
            begin
                left_s  = head_rec.word[15:0];
                right_s = stereo ? head_rec.word[31:16] : head_rec.word[15:0];
            end
            else
            begin
                left_s  = {head_rec.word[7:0] ^ PCM_OFFSET, 8'd0};
                right_s = stereo ? {head_rec.word[15:8] ^ PCM_OFFSET, 8'd0} : left_s;
            end
        end
        else if (head_rec.kind == KIND_HEADER)
        begin
            rate_f   = head_rec.rate;
            ch_f     = head_rec.channels;
            bits_f   = head_rec.width_16 ? 5'd16 : 5'd8;
            frames_f = head_rec.word;
        end
        data_next = {6'd0, frames_f, bits_f, ch_f, rate_f, right_s, left_s, head_rec.status};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (m_axis_tready)
            valid_reg <= 1'b0;
    end

    // Load output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= data_next;
            user_reg <= head_rec.kind;
            last_reg <= head_rec.fin;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !m_axis_tready |-> !pop)
        else $error("output overwritten while stalled");
    a_fill_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !valid_reg |=> valid_reg)
        else $error("output register not filled");
    a_last_only_end: assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_rec.kind == KIND_ERROR |-> head_rec.fin)
        else $error("error result not final");

endmodule

FILE: src/wav_stream_pcm_decoder_core.sv
// WAV stream PCM decoder: one file byte per beat in, one result per beat out.
// Throughput: one byte per cycle while the queue is not full; the parser never stalls.
// Each result is written to the queue at the edge that accepts its byte and is
// then loaded into the output register once that register is free.
// The queue (QUEUE_DEPTH entries) absorbs output stalls; s_axis_tready drops when full.
// Reset (rst_n low, asynchronous) returns the parser to the RIFF magic and empties
// the queue and output register; the parser also restarts after every end-of-file byte.
module wav_stream_pcm_decoder_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] file_byte
    input  logic         s_axis_tlast,   // end_of_file
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [3:0] status_code, [19:4] left_sample, [35:20] right_sample,
    // [66:36] sample_rate, [68:67] channel_count, [73:69] bits_per_channel,
    // [105:74] frame_count, [111:106] zero
    output logic [111:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] result_kind
    output logic         m_axis_tlast    // final_result
);
    import wsp_pkg::*;

    logic     in_fire;
    logic     push, full, pop, head_valid;
    wsp_rec_t push_rec, head_rec;

    assign s_axis_tready = !full;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Classify bytes
    wsp_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .file_byte   (s_axis_tdata),
        .end_of_file (s_axis_tlast),
        .push        (push),
        .rec         (push_rec)
    );

    // Queue results
    wsp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_rec   (push_rec),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Format and drive result beats
    wsp_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_rec      (head_rec),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
